[hw/rtl/pdc_pkg.sv]
// Package for the PWM period/duty capture block.
// Holds the counter width, field widths, queue entry and back-end state types.
// No dependencies.
package pdc_pkg;

   // free-running tick counter width
   localparam int COUNT_WIDTH = 32;

   // result field widths
   localparam int TIME_W  = 32;
   localparam int FREQ_W  = 30;
   localparam int DUTY_W  = 7;

   // timebase register
   localparam logic [FREQ_W-1:0] TIMEBASE_RESET = FREQ_W'(1000000);

   // percent scale and its value on the duty field
   localparam logic [DUTY_W-1:0] PERCENT_FULL = DUTY_W'(100);

   // iteration counts of the two long divisions
   localparam int FREQ_STEPS = FREQ_W;
   localparam int DUTY_STEPS = DUTY_W;
   localparam int STEP_W     = $clog2(FREQ_STEPS);

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   // cycle progress codes
   localparam logic [1:0] PROG_NONE      = 2'd0;
   localparam logic [1:0] PROG_RISE      = 2'd1;
   localparam logic [1:0] PROG_RISE_FALL = 2'd2;

   // widened width for saturating a count onto a 32-bit field
   localparam int EXT_W = (COUNT_WIDTH > TIME_W) ? COUNT_WIDTH : TIME_W;

   // one measured cycle handed from front to back
   typedef struct packed {
      logic [COUNT_WIDTH-1:0] period;
      logic [COUNT_WIDTH-1:0] high;
   } meas_type;

   // back-end sequencer
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_HOLD = 3'b100
   } back_state_type;

   // clamp a counter-width value onto a 32-bit result field
   function automatic logic [TIME_W-1:0] sat_time(input logic [COUNT_WIDTH-1:0] v);
      logic [EXT_W-1:0] ext;
      ext = EXT_W'(v);
      if (ext > EXT_W'({TIME_W{1'b1}})) begin
         sat_time = {TIME_W{1'b1}};
      end else begin
         sat_time = ext[TIME_W-1:0];
      end
   endfunction

endpackage

[hw/rtl/pwm_period_duty_capture.sv]
// Top level of the PWM period/duty capture block.
// Instantiates pdc_front, pdc_queue and pdc_back; holds the timebase register. Uses pdc_pkg.
//
//   port group  dir  handshake            payload
//   req_        in   req_valid/req_ready  req_pin_level (one timebase tick)
//   rsp_        out  rsp_valid/rsp_ready  period, high time, frequency, duty
//   csr_        in   csr_wr_en            csr_wr_data (timebase_hz)
//
// One tick beat is taken per cycle while the measurement queue has room.
// Each measurement then passes through the back end in order: one load, 30 steps of the
// bit-serial frequency divider (duty finishes in the first 7), one output load.
// The 4-entry queue absorbs edges while the back end is busy; when full, req_ready drops.
// Reset is synchronous; the timebase returns to 1000000 ticks per second.
module pwm_period_duty_capture (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_pin_level,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [pdc_pkg::TIME_W-1:0]  rsp_period_ticks,
   output logic [pdc_pkg::TIME_W-1:0]  rsp_high_ticks,
   output logic [pdc_pkg::FREQ_W-1:0]  rsp_frequency_hz,
   output logic [pdc_pkg::DUTY_W-1:0]  rsp_duty_percent,
   input  logic                        csr_wr_en,
   input  logic [pdc_pkg::FREQ_W-1:0]  csr_wr_data
);
   import pdc_pkg::*;

   logic [FREQ_W-1:0] timebase_ff;
   logic              q_full;
   logic              q_empty;
   logic              q_push;
   logic              q_pop;
   meas_type          q_push_data;
   meas_type          q_pop_data;

   // timebase register
   always_ff @(posedge clock) begin
      if (reset) begin
         timebase_ff <= TIMEBASE_RESET;
      end else if (csr_wr_en) begin
         timebase_ff <= csr_wr_data;
      end
   end

   pdc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pin_level (req_pin_level),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_push_data   (q_push_data)
   );

   pdc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_pop_data)
   );

   pdc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .timebase         (timebase_ff),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .q_pop_data       (q_pop_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_period_ticks (rsp_period_ticks),
      .rsp_high_ticks   (rsp_high_ticks),
      .rsp_frequency_hz (rsp_frequency_hz),
      .rsp_duty_percent (rsp_duty_percent)
   );

endmodule

[hw/rtl/pdc_front.sv]
// Front end: edge detection and time stamping of the sampled pin.
// Pushes one measurement per completed rise-fall-rise cycle. Uses pdc_pkg.
module pdc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_pin_level,
   input  logic              q_full,
   output logic              q_push,
   output pdc_pkg::meas_type q_push_data
);
   import pdc_pkg::*;

   logic                   last_level_ff, last_level_in;
   logic [COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic [COUNT_WIDTH-1:0] latest_ff, latest_in;
   logic [COUNT_WIDTH-1:0] earlier_ff, earlier_in;
   logic [COUNT_WIDTH-1:0] fall_ff, fall_in;
   logic [1:0]             prog_ff, prog_in;
   logic                   accept;
   logic                   rise;
   logic                   fall;

   // a tick is taken only while the queue has room for its possible result
   assign req_ready = ~q_full;
   assign accept    = req_valid & req_ready;
   assign rise      = req_pin_level & ~last_level_ff;
   assign fall      = ~req_pin_level & last_level_ff;

   // measurement closed by this rising edge
   assign q_push             = accept & rise & (prog_ff == PROG_RISE_FALL);
   assign q_push_data.period = tick_ff - latest_ff;
   assign q_push_data.high   = fall_ff - latest_ff;

   // edge bookkeeping
   always_comb begin
      last_level_in = last_level_ff;
      tick_in       = tick_ff;
      latest_in     = latest_ff;
      earlier_in    = earlier_ff;
      fall_in       = fall_ff;
      prog_in       = prog_ff;
      if (accept) begin
         last_level_in = req_pin_level;
         tick_in       = tick_ff + COUNT_WIDTH'(1);
         if (rise) begin
            earlier_in = latest_ff;
            latest_in  = tick_ff;
            prog_in    = PROG_RISE;
         end else if (fall) begin
            fall_in = tick_ff;
            if (prog_ff == PROG_RISE || prog_ff == PROG_RISE_FALL) begin
               prog_in = PROG_RISE_FALL;
            end else begin
               prog_in = PROG_NONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff <= 1'b0;
         tick_ff       <= '0;
         latest_ff     <= '0;
         earlier_ff    <= '0;
         fall_ff       <= '0;
         prog_ff       <= PROG_NONE;
      end else begin
         last_level_ff <= last_level_in;
         tick_ff       <= tick_in;
         latest_ff     <= latest_in;
         earlier_ff    <= earlier_in;
         fall_ff       <= fall_in;
         prog_ff       <= prog_in;
      end
   end

endmodule

[hw/rtl/pdc_queue.sv]
// Short queue of measurements between front and back end.
// Flop storage, one push and one pop port. Uses pdc_pkg.
module pdc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pdc_pkg::meas_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output pdc_pkg::meas_type pop_data
);
   import pdc_pkg::*;

   meas_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/pdc_back.sv]
// Back end: bit-serial division for frequency and duty, then output register.
// Frequency takes one quotient bit per cycle, duty runs alongside. Uses pdc_pkg.
module pdc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [pdc_pkg::FREQ_W-1:0]  timebase,
   input  logic                        q_empty,
   output logic                        q_pop,
   input  pdc_pkg::meas_type           q_pop_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [pdc_pkg::TIME_W-1:0]  rsp_period_ticks,
   output logic [pdc_pkg::TIME_W-1:0]  rsp_high_ticks,
   output logic [pdc_pkg::FREQ_W-1:0]  rsp_frequency_hz,
   output logic [pdc_pkg::DUTY_W-1:0]  rsp_duty_percent
);
   import pdc_pkg::*;

   localparam int PROD_W = COUNT_WIDTH + DUTY_W;

   back_state_type         state_ff, state_in;
   logic [STEP_W-1:0]      step_ff;
   logic [COUNT_WIDTH-1:0] period_ff;
   logic [COUNT_WIDTH-1:0] high_ff;
   logic [FREQ_W-1:0]      fnum_ff;
   logic [COUNT_WIDTH-1:0] frem_ff;
   logic [FREQ_W-1:0]      fquo_ff;
   logic [COUNT_WIDTH-1:0] drem_ff;
   logic [DUTY_W-1:0]      dlow_ff;
   logic [DUTY_W-1:0]      dquo_ff;
   logic                   rsp_valid_ff;
   logic [TIME_W-1:0]      out_period_ff;
   logic [TIME_W-1:0]      out_high_ff;
   logic [FREQ_W-1:0]      out_freq_ff;
   logic [DUTY_W-1:0]      out_duty_ff;

   logic [PROD_W-1:0]      prod;
   logic [COUNT_WIDTH:0]   ftrial;
   logic [COUNT_WIDTH:0]   dtrial;
   logic                   fgo;
   logic                   dgo;
   logic                   last_step;
   logic                   out_free;
   logic                   load_out;
   logic                   period_zero;
   logic [FREQ_W-1:0]      freq_final;
   logic [DUTY_W-1:0]      duty_final;

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign q_pop     = (state_ff == ST_IDLE) & ~q_empty;
   assign load_out  = (state_ff == ST_HOLD) & out_free;
   assign last_step = (step_ff == STEP_W'(FREQ_STEPS - 1));

   // high * 100 as shift-adds; quotient stays below 2^DUTY_W when high < period
   assign prod = (PROD_W'(q_pop_data.high) << 6) + (PROD_W'(q_pop_data.high) << 5)
               + (PROD_W'(q_pop_data.high) << 2);

   // restoring division steps
   assign ftrial = {frem_ff, fnum_ff[FREQ_W-1]};
   assign fgo    = (ftrial >= {1'b0, period_ff});
   assign dtrial = {drem_ff, dlow_ff[DUTY_W-1]};
   assign dgo    = (dtrial >= {1'b0, period_ff});

   // special cases on the final values
   assign period_zero = (period_ff == '0);
   always_comb begin
      if (period_zero) begin
         freq_final = '0;
         duty_final = '0;
      end else begin
         freq_final = fquo_ff;
         if (high_ff >= period_ff) begin
            duty_final = PERCENT_FULL;
         end else begin
            duty_final = dquo_ff;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (last_step) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // division datapath
   always_ff @(posedge clock) begin
      if (q_pop) begin
         period_ff <= q_pop_data.period;
         high_ff   <= q_pop_data.high;
         fnum_ff   <= timebase;
         frem_ff   <= '0;
         fquo_ff   <= '0;
         drem_ff   <= prod[PROD_W-1:DUTY_W];
         dlow_ff   <= prod[DUTY_W-1:0];
         dquo_ff   <= '0;
         step_ff   <= '0;
      end else if (state_ff == ST_DIV) begin
         step_ff <= step_ff + STEP_W'(1);
         fnum_ff <= fnum_ff << 1;
         fquo_ff <= {fquo_ff[FREQ_W-2:0], fgo};
         if (fgo) begin
            frem_ff <= COUNT_WIDTH'(ftrial - {1'b0, period_ff});
         end else begin
            frem_ff <= ftrial[COUNT_WIDTH-1:0];
         end
         if (step_ff < STEP_W'(DUTY_STEPS)) begin
            dlow_ff <= dlow_ff << 1;
            dquo_ff <= {dquo_ff[DUTY_W-2:0], dgo};
            if (dgo) begin
               drem_ff <= COUNT_WIDTH'(dtrial - {1'b0, period_ff});
            end else begin
               drem_ff <= dtrial[COUNT_WIDTH-1:0];
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_period_ff <= sat_time(period_ff);
         out_high_ff   <= sat_time(high_ff);
         out_freq_ff   <= freq_final;
         out_duty_ff   <= duty_final;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_period_ticks = out_period_ff;
   assign rsp_high_ticks   = out_high_ff;
   assign rsp_frequency_hz = out_freq_ff;
   assign rsp_duty_percent = out_duty_ff;

endmodule
